// ===== design/mpfb_pkg.sv =====
// Shared types and constants for the page framebuffer text renderer.
package mpfb_pkg;

    localparam int FUNC_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_FILL       = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIXEL      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_CURSOR = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CHAR       = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_GLYPH = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ_BYTE  = 3'd5;

    localparam logic CFG_FONT_WIDTH  = 1'b0;
    localparam logic CFG_FONT_HEIGHT = 1'b1;

    localparam logic [7:0] FIRST_CHAR = 8'd32;
    localparam logic [7:0] LAST_CHAR  = 8'd126;
    localparam int         CHAR_COUNT = 95;

    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BIT_ONE   = 8'h01;

    localparam logic [4:0] FONT_WIDTH_RST  = 5'd7;
    localparam logic [4:0] FONT_HEIGHT_RST = 5'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // request accepted, latch its fields
        logic fill_start;  // start a fill sweep with the latched color
        logic sweep;       // write one byte of the sweep
        logic char_init;   // clear the glyph row and column counters
        logic glyph_rd;    // fetch the glyph row for the current row counter
        logic pix_rd;      // read the byte under the current pixel
        logic pix_wr;      // write back the modified byte
        logic col_step;    // next column
        logic row_step;    // next row, column back to zero
        logic cur_adv;     // advance the cursor by the font width
        logic byte_rd;     // read the byte at the requested address
        logic fin;         // load the result into the output register
    } mpfb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              char_ok;
        logic              size_zero;
        logic              sweep_last;
        logic              col_last;
        logic              row_last;
        logic              out_free;
    } mpfb_status_t;

endpackage

// ===== design/mpfb_ctrl.sv =====
// Controller state machine of the page framebuffer text renderer.
module mpfb_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  mpfb_pkg::mpfb_status_t       status,
    output mpfb_pkg::mpfb_cmd_t          cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_FILL  = 4'd3;
    localparam logic [3:0] S_GROW  = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PWR   = 4'd6;
    localparam logic [3:0] S_CADV  = 4'd7;
    localparam logic [3:0] S_RDB   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.sweep = 1'b1;
                if (status.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                unique case (status.func)
                    mpfb_pkg::FUNC_FILL: begin
                        cmd.fill_start = 1'b1;
                        state_next     = S_FILL;
                    end
                    mpfb_pkg::FUNC_PIXEL: begin
                        state_next = S_PRD;
                    end
                    mpfb_pkg::FUNC_CHAR: begin
                        if (!status.char_ok) begin
                            state_next = S_FIN;
                        end else if (status.size_zero) begin
                            state_next = S_CADV;
                        end else begin
                            cmd.char_init = 1'b1;
                            state_next    = S_GROW;
                        end
                    end
                    mpfb_pkg::FUNC_READ_BYTE: begin
                        state_next = S_RDB;
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FILL: begin
                cmd.sweep = 1'b1;
                if (status.sweep_last) begin
                    state_next = S_FIN;
                end
            end
            S_GROW: begin
                cmd.glyph_rd = 1'b1;
                state_next   = S_PRD;
            end
            S_PRD: begin
                cmd.pix_rd = 1'b1;
                state_next = S_PWR;
            end
            S_PWR: begin
                cmd.pix_wr = 1'b1;
                if (status.func != mpfb_pkg::FUNC_CHAR) begin
                    state_next = S_FIN;
                end else if (!status.col_last) begin
                    cmd.col_step = 1'b1;
                    state_next   = S_PRD;
                end else if (!status.row_last) begin
                    cmd.row_step = 1'b1;
                    state_next   = S_GROW;
                end else begin
                    state_next = S_CADV;
                end
            end
            S_CADV: begin
                cmd.cur_adv = 1'b1;
                state_next  = S_FIN;
            end
            S_RDB: begin
                cmd.byte_rd = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN: begin
                // Wait here only while the previous result is still unclaimed.
                if (status.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/mpfb_dp.sv =====
// Datapath of the page framebuffer text renderer: stores, counters and result register.
module mpfb_dp #(
    parameter int SCREEN_WIDTH   = 128,
    parameter int SCREEN_HEIGHT  = 64,
    parameter int MAX_GLYPH_ROWS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [4:0]             cfg_wdata,
    input  logic [2:0]             s_func,
    input  logic [7:0]             s_x_coord,
    input  logic [7:0]             s_y_coord,
    input  logic                   s_color,
    input  logic [7:0]             s_char_code,
    input  logic [3:0]             s_glyph_row_index,
    input  logic [15:0]            s_glyph_row_bits,
    input  logic [9:0]             s_byte_address,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_result_value,
    input  mpfb_pkg::mpfb_cmd_t    cmd,
    output mpfb_pkg::mpfb_status_t status
);

    localparam int FB_BYTES   = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
    localparam int FB_AW      = $clog2(FB_BYTES);
    localparam int GL_ENTRIES = mpfb_pkg::CHAR_COUNT * MAX_GLYPH_ROWS;
    localparam int GL_AW      = $clog2(GL_ENTRIES);

    localparam logic [8:0]       WIDTH_LIM  = 9'(SCREEN_WIDTH);
    localparam logic [8:0]       HEIGHT_LIM = 9'(SCREEN_HEIGHT);
    localparam logic [15:0]      FB_LIM     = 16'(FB_BYTES);
    localparam logic [4:0]       GROWS_LIM  = 5'(MAX_GLYPH_ROWS);
    localparam logic [FB_AW-1:0] SWEEP_END  = FB_AW'(FB_BYTES - 1);

    logic [7:0]  frame_mem [FB_BYTES];
    logic [15:0] glyph_mem [GL_ENTRIES];

    // Control state.
    logic [4:0]       font_width_reg;
    logic [4:0]       font_height_reg;
    logic [7:0]       cursor_col_reg;
    logic [7:0]       cursor_row_reg;
    logic [FB_AW-1:0] sweep_reg;
    logic [7:0]       fill_val_reg;
    logic             m_valid_reg;

    // Latched request and per-pixel payload.
    logic [2:0]       func_reg;
    logic [7:0]       x_reg;
    logic [7:0]       y_reg;
    logic             color_reg;
    logic [7:0]       ch_reg;
    logic [9:0]       baddr_reg;
    logic [4:0]       r_reg;
    logic [4:0]       c_reg;
    logic [15:0]      gl_rdata_reg;
    logic             row_ok_reg;
    logic [7:0]       fb_rdata_reg;
    logic             rd_ok_reg;
    logic [FB_AW-1:0] pix_addr_reg;
    logic [2:0]       pix_bit_reg;
    logic             pix_val_reg;
    logic             pix_ok_reg;
    logic [7:0]       m_result_value_reg;

    logic             char_ok;
    logic             load_char_ok;
    logic             load_glyph_we;
    logic [GL_AW-1:0] load_gaddr;
    logic [GL_AW-1:0] rd_gaddr;
    logic [7:0]       px;
    logic [7:0]       py;
    logic             pix_ok;
    logic             gbit;
    logic             pix_val;
    logic [15:0]      pix_idx_full;
    logic [FB_AW-1:0] pix_idx;
    logic             rd_ok;
    logic [7:0]       bit_mask;
    logic [7:0]       new_byte;
    logic [7:0]       res_c;

    assign char_ok = (ch_reg >= mpfb_pkg::FIRST_CHAR) && (ch_reg <= mpfb_pkg::LAST_CHAR);
    assign load_char_ok = (s_char_code >= mpfb_pkg::FIRST_CHAR)
                       && (s_char_code <= mpfb_pkg::LAST_CHAR);
    assign load_glyph_we = cmd.load && (s_func == mpfb_pkg::FUNC_LOAD_GLYPH) && load_char_ok
                        && ({1'b0, s_glyph_row_index} < GROWS_LIM);
    assign load_gaddr = GL_AW'(16'(s_char_code - mpfb_pkg::FIRST_CHAR) * 16'(MAX_GLYPH_ROWS)
                        + 16'(s_glyph_row_index));
    assign rd_gaddr   = GL_AW'(16'(ch_reg - mpfb_pkg::FIRST_CHAR) * 16'(MAX_GLYPH_ROWS)
                        + 16'(r_reg));

    // Character pixels sit at cursor plus offset, wrapping at eight bits.
    always_comb begin
        if (func_reg == mpfb_pkg::FUNC_CHAR) begin
            px = cursor_col_reg + {3'b000, c_reg};
            py = cursor_row_reg + {3'b000, r_reg};
        end else begin
            px = x_reg;
            py = y_reg;
        end
    end

    // Rows past the table and columns past sixteen read as clear bits.
    assign gbit    = row_ok_reg && !c_reg[4] && gl_rdata_reg[c_reg[3:0]];
    assign pix_val = (func_reg == mpfb_pkg::FUNC_CHAR) ? (color_reg ^ ~gbit) : color_reg;
    assign pix_ok  = ({1'b0, px} < WIDTH_LIM) && ({1'b0, py} < HEIGHT_LIM);
    assign pix_idx_full = 16'(px) + 16'(py[7:3]) * 16'(SCREEN_WIDTH);
    assign pix_idx = FB_AW'(pix_idx_full);
    assign rd_ok   = (16'(baddr_reg) < FB_LIM);

    assign bit_mask = 8'(mpfb_pkg::BIT_ONE << pix_bit_reg);
    assign new_byte = pix_val_reg ? (fb_rdata_reg | bit_mask) : (fb_rdata_reg & ~bit_mask);

    always_comb begin
        case (func_reg)
            mpfb_pkg::FUNC_READ_BYTE: res_c = rd_ok_reg ? fb_rdata_reg : 8'h00;
            mpfb_pkg::FUNC_CHAR:      res_c = char_ok ? ch_reg : 8'h00;
            default:                  res_c = 8'h00;
        endcase
    end

    assign status.func       = func_reg;
    assign status.char_ok    = char_ok;
    assign status.size_zero  = (font_width_reg == 5'd0) || (font_height_reg == 5'd0);
    assign status.sweep_last = (sweep_reg == SWEEP_END);
    assign status.col_last   = (c_reg == font_width_reg - 5'd1);
    assign status.row_last   = (r_reg == font_height_reg - 5'd1);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_width_reg  <= mpfb_pkg::FONT_WIDTH_RST;
            font_height_reg <= mpfb_pkg::FONT_HEIGHT_RST;
            cursor_col_reg  <= 8'h00;
            cursor_row_reg  <= 8'h00;
            sweep_reg       <= '0;
            fill_val_reg    <= 8'h00;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == mpfb_pkg::CFG_FONT_WIDTH) begin
                    font_width_reg <= cfg_wdata;
                end else begin
                    font_height_reg <= cfg_wdata;
                end
            end
            if (cmd.load && (s_func == mpfb_pkg::FUNC_SET_CURSOR)) begin
                cursor_col_reg <= s_x_coord;
                cursor_row_reg <= s_y_coord;
            end else if (cmd.cur_adv) begin
                cursor_col_reg <= cursor_col_reg + {3'b000, font_width_reg};
            end
            if (cmd.fill_start) begin
                sweep_reg    <= '0;
                fill_val_reg <= color_reg ? mpfb_pkg::BYTE_ONES : 8'h00;
            end else if (cmd.sweep) begin
                sweep_reg <= sweep_reg + FB_AW'(1);
            end
            if (cmd.fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            x_reg     <= s_x_coord;
            y_reg     <= s_y_coord;
            color_reg <= s_color;
            ch_reg    <= s_char_code;
            baddr_reg <= s_byte_address;
        end
        if (cmd.char_init) begin
            r_reg <= 5'd0;
            c_reg <= 5'd0;
        end else if (cmd.row_step) begin
            r_reg <= r_reg + 5'd1;
            c_reg <= 5'd0;
        end else if (cmd.col_step) begin
            c_reg <= c_reg + 5'd1;
        end
        if (cmd.glyph_rd) begin
            row_ok_reg <= (r_reg < GROWS_LIM);
        end
        if (cmd.pix_rd) begin
            pix_addr_reg <= pix_idx;
            pix_bit_reg  <= py[2:0];
            pix_val_reg  <= pix_val;
            pix_ok_reg   <= pix_ok;
        end
        if (cmd.byte_rd) begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.fin) begin
            m_result_value_reg <= res_c;
        end
    end

    // Glyph store: written on a glyph load, read once per rendered row within the table.
    always_ff @(posedge aclk) begin
        if (load_glyph_we) begin
            glyph_mem[load_gaddr] <= s_glyph_row_bits;
        end
        if (cmd.glyph_rd && (r_reg < GROWS_LIM)) begin
            gl_rdata_reg <= glyph_mem[rd_gaddr];
        end
    end

    // Frame store: one write port shared by sweeps and pixel write-backs.
    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            frame_mem[sweep_reg] <= fill_val_reg;
        end else if (cmd.pix_wr && pix_ok_reg) begin
            frame_mem[pix_addr_reg] <= new_byte;
        end
        if (cmd.pix_rd && pix_ok) begin
            fb_rdata_reg <= frame_mem[pix_idx];
        end else if (cmd.byte_rd && rd_ok) begin
            fb_rdata_reg <= frame_mem[FB_AW'(baddr_reg)];
        end
    end

    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pix_wr |-> $past(cmd.pix_rd))
        else $error("pixel write-back without a preceding read");

    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an unclaimed result");

    a_glyph_char: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.glyph_rd |-> (func_reg == mpfb_pkg::FUNC_CHAR) && char_ok)
        else $error("glyph fetch outside a printable character");

    a_adv_char: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cur_adv |=> (cursor_col_reg == $past(cursor_col_reg + {3'b000, font_width_reg})))
        else $error("cursor did not advance by the font width");

endmodule

// ===== design/mono_page_framebuffer_text_render.sv =====
// Top level of the monochrome page framebuffer with text cursor.
//
// Requests enter on the s_ channel (valid/ready) and each produces exactly one
// result on the m_ channel (valid/ready). Font width and height are set through
// the plain write port (cfg_wr_en, cfg_index, cfg_wdata); the user must write
// them only while the block is idle; the block itself does not enforce this.
// One request is worked at a time; the frame store has a single read and a single
// write port, and every pixel is one read followed by one write-back.
// A fill sweeps every byte of the frame store; a printable character is drawn
// row by row, each of its pixels read and written back; a character with a zero
// size only advances the cursor.
// After reset the block sweeps zeros through all FB_BYTES bytes of the frame store
// (1024 at the default size) with s_ready low; configuration writes still land.
// A new request is accepted as soon as the previous one is finished, even while
// its result waits in the output register. A request whose result finds that
// register still full holds until the receiver takes the old one.
module mono_page_framebuffer_text_render #(
    parameter int SCREEN_WIDTH   = 128,
    parameter int SCREEN_HEIGHT  = 64,
    parameter int MAX_GLYPH_ROWS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [7:0]  s_x_coord,
    input  logic [7:0]  s_y_coord,
    input  logic        s_color,
    input  logic [7:0]  s_char_code,
    input  logic [3:0]  s_glyph_row_index,
    input  logic [15:0] s_glyph_row_bits,
    input  logic [9:0]  s_byte_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_result_value
);

    mpfb_pkg::mpfb_cmd_t    cmd;
    mpfb_pkg::mpfb_status_t status;

    mpfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mpfb_dp #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_func            (s_func),
        .s_x_coord         (s_x_coord),
        .s_y_coord         (s_y_coord),
        .s_color           (s_color),
        .s_char_code       (s_char_code),
        .s_glyph_row_index (s_glyph_row_index),
        .s_glyph_row_bits  (s_glyph_row_bits),
        .s_byte_address    (s_byte_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_value    (m_result_value),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

// ===== sim/tb_mono_page_framebuffer_text_render.sv =====
// Self-checking testbench for the monochrome page framebuffer text renderer.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_text_render;

    localparam int SCREEN_W      = 128;
    localparam int SCREEN_H      = 64;
    localparam int GLYPH_ROWS    = 16;
    localparam int FB_BYTES      = SCREEN_W * ((SCREEN_H + 7) / 8);
    localparam int GLYPH_ENTRIES = mpfb_pkg::CHAR_COUNT * GLYPH_ROWS;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 167;

    // Function codes the block does not decode.
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  x_coord;
        logic [7:0]  y_coord;
        logic        color;
        logic [7:0]  char_code;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic [9:0]  byte_address;
    } fb_req_t;

    class fb_predictor;
        logic [7:0]  frame[FB_BYTES];
        logic [15:0] glyph[GLYPH_ENTRIES];
        logic [7:0]  cur_col;
        logic [7:0]  cur_row;
        logic [4:0]  font_w;
        logic [4:0]  font_h;
        logic [7:0]  due_results[$];
        int          errors;

        function new();
            errors = 0;
            foreach (frame[i]) frame[i] = 8'h00;
            foreach (glyph[i]) glyph[i] = 16'h0000;
            cur_col = 8'h00;
            cur_row = 8'h00;
            font_w  = mpfb_pkg::FONT_WIDTH_RST;
            font_h  = mpfb_pkg::FONT_HEIGHT_RST;
        endfunction

        function void write_reg(logic idx, logic [4:0] value);
            if (idx == mpfb_pkg::CFG_FONT_WIDTH) begin
                font_w = value;
            end else begin
                font_h = value;
            end
        endfunction

        function void plot(int px, int py, logic on);
            int idx;
            if (px >= SCREEN_W || py >= SCREEN_H) begin
                return;
            end
            idx = px + (py / 8) * SCREEN_W;
            frame[idx][py % 8] = on;
        endfunction

        function logic [7:0] render(logic [7:0] ch, logic color);
            logic [15:0] bits;
            logic [7:0]  px;
            logic [7:0]  py;
            logic        on;
            int          base;
            if (ch < mpfb_pkg::FIRST_CHAR || ch > mpfb_pkg::LAST_CHAR) begin
                return 8'h00;
            end
            base = (int'(ch) - int'(mpfb_pkg::FIRST_CHAR)) * GLYPH_ROWS;
            for (int r = 0; r < font_h; r++) begin
                bits = (r < GLYPH_ROWS) ? glyph[base + r] : 16'h0000;
                py = cur_row + 8'(r);
                for (int c = 0; c < font_w; c++) begin
                    px = cur_col + 8'(c);
                    // Columns past the glyph row width always read as clear.
                    on = ~color;
                    if (c < 16) begin
                        if (bits[c]) on = color;
                    end
                    plot(px, py, on);
                end
            end
            cur_col = cur_col + 8'(font_w);
            return ch;
        endfunction

        function void note_request(fb_req_t q);
            logic [7:0] res;
            res = 8'h00;
            case (q.func)
                mpfb_pkg::FUNC_FILL: begin
                    foreach (frame[i]) frame[i] = q.color ? mpfb_pkg::BYTE_ONES : 8'h00;
                end
                mpfb_pkg::FUNC_PIXEL: begin
                    plot(q.x_coord, q.y_coord, q.color);
                end
                mpfb_pkg::FUNC_SET_CURSOR: begin
                    cur_col = q.x_coord;
                    cur_row = q.y_coord;
                end
                mpfb_pkg::FUNC_CHAR: begin
                    res = render(q.char_code, q.color);
                end
                mpfb_pkg::FUNC_LOAD_GLYPH: begin
                    if (q.char_code >= mpfb_pkg::FIRST_CHAR
                        && q.char_code <= mpfb_pkg::LAST_CHAR
                        && q.row_index < GLYPH_ROWS) begin
                        glyph[(int'(q.char_code) - int'(mpfb_pkg::FIRST_CHAR)) * GLYPH_ROWS
                              + q.row_index] = q.row_bits;
                    end
                end
                mpfb_pkg::FUNC_READ_BYTE: begin
                    if (q.byte_address < FB_BYTES) res = frame[q.byte_address];
                end
                default: begin
                end
            endcase
            due_results.push_back(res);
        endfunction

        task report(string what);
            $display("%0t ns: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [7:0] got);
            logic [7:0] want;
            if (due_results.size() == 0) begin
                report($sformatf("result 0x%02h with no request outstanding", got));
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                report($sformatf("result_value 0x%02h, expected 0x%02h", got, want));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [4:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [7:0]  s_x_coord;
    logic [7:0]  s_y_coord;
    logic        s_color;
    logic [7:0]  s_char_code;
    logic [3:0]  s_glyph_row_index;
    logic [15:0] s_glyph_row_bits;
    logic [9:0]  s_byte_address;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_result_value;

    fb_predictor sb;
    bit          glyph_loaded[GLYPH_ENTRIES];
    int          idle_pct;
    int          stall_pct;
    int          sent_count;

    int phase_w[PHASES]     = '{7, 1, 16, 0, 5, 31, 3, 20, 8};
    int phase_h[PHASES]     = '{10, 1, 16, 6, 0, 31, 16, 3, 8};
    int idle_by_mode[4]     = '{0, 49, 0, 24};
    int stall_by_mode[4]    = '{0, 0, 49, 24};

    mono_page_framebuffer_text_render #(
        .SCREEN_WIDTH   (SCREEN_W),
        .SCREEN_HEIGHT  (SCREEN_H),
        .MAX_GLYPH_ROWS (GLYPH_ROWS)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_x_coord         (s_x_coord),
        .s_y_coord         (s_y_coord),
        .s_color           (s_color),
        .s_char_code       (s_char_code),
        .s_glyph_row_index (s_glyph_row_index),
        .s_glyph_row_bits  (s_glyph_row_bits),
        .s_byte_address    (s_byte_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_value    (m_result_value)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_result_value);
    end

    function automatic fb_req_t make_req(logic [2:0] f, logic [7:0] x, logic [7:0] y,
                                         logic color, logic [7:0] ch, logic [3:0] row,
                                         logic [9:0] addr);
        fb_req_t q;
        q.func         = f;
        q.x_coord      = x;
        q.y_coord      = y;
        q.color        = color;
        q.char_code    = ch;
        q.row_index    = row;
        q.row_bits     = 16'($urandom_range(0, 65535));
        q.byte_address = addr;
        return q;
    endfunction

    function automatic fb_req_t random_req();
        fb_req_t q;
        int      pick;
        q = make_req(FUNC_SPARE_6, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
        pick = $urandom_range(99);
        if (pick < 2) begin
            q.func = mpfb_pkg::FUNC_FILL;
        end else if (pick < 27) begin
            q.func = mpfb_pkg::FUNC_PIXEL;
            if ($urandom_range(9) < 8) q.x_coord = 8'($urandom_range(0, SCREEN_W - 1));
            if ($urandom_range(9) < 8) q.y_coord = 8'($urandom_range(0, SCREEN_H - 1));
        end else if (pick < 37) begin
            q.func = mpfb_pkg::FUNC_SET_CURSOR;
            if ($urandom_range(9) < 7) q.x_coord = 8'($urandom_range(0, SCREEN_W - 1));
            if ($urandom_range(9) < 7) q.y_coord = 8'($urandom_range(0, SCREEN_H - 1));
        end else if (pick < 57) begin
            q.func = mpfb_pkg::FUNC_CHAR;
            pick = $urandom_range(9);
            // Mostly a small set of characters so their glyphs get reused.
            if (pick < 6) begin
                q.char_code = 8'(65 + $urandom_range(0, 5));
            end else if (pick < 8) begin
                q.char_code = 8'($urandom_range(mpfb_pkg::FIRST_CHAR, mpfb_pkg::LAST_CHAR));
            end
        end else if (pick < 70) begin
            q.func = mpfb_pkg::FUNC_LOAD_GLYPH;
            pick = $urandom_range(9);
            if (pick < 5) begin
                q.char_code = 8'(65 + $urandom_range(0, 5));
            end else if (pick < 8) begin
                q.char_code = 8'($urandom_range(mpfb_pkg::FIRST_CHAR, mpfb_pkg::LAST_CHAR));
            end
        end else if (pick < 95) begin
            q.func = mpfb_pkg::FUNC_READ_BYTE;
            // Half the reads look near the cursor, where text has been drawn.
            if ($urandom_range(1) == 1) begin
                q.byte_address = 10'(((sb.cur_row % SCREEN_H) / 8) * SCREEN_W
                                     + (sb.cur_col + $urandom_range(0, 20)) % SCREEN_W);
            end
        end else if (pick < 97) begin
            q.func = FUNC_SPARE_6;
        end else begin
            q.func = FUNC_SPARE_7;
        end
        return q;
    endfunction

    task automatic send_req(fb_req_t q);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_func            = q.func;
        s_x_coord         = q.x_coord;
        s_y_coord         = q.y_coord;
        s_color           = q.color;
        s_char_code       = q.char_code;
        s_glyph_row_index = q.row_index;
        s_glyph_row_bits  = q.row_bits;
        s_byte_address    = q.byte_address;
        s_valid           = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(q);
        sent_count++;
        if (q.func == mpfb_pkg::FUNC_LOAD_GLYPH && q.char_code >= mpfb_pkg::FIRST_CHAR
            && q.char_code <= mpfb_pkg::LAST_CHAR) begin
            glyph_loaded[(int'(q.char_code) - int'(mpfb_pkg::FIRST_CHAR)) * GLYPH_ROWS
                         + q.row_index] = 1'b1;
        end
        @(negedge aclk);
    endtask

    // A character may only be drawn once every glyph row it reads has been loaded.
    task automatic issue(fb_req_t q);
        fb_req_t ld;
        int      need;
        int      base;
        if (q.func == mpfb_pkg::FUNC_CHAR && q.char_code >= mpfb_pkg::FIRST_CHAR
            && q.char_code <= mpfb_pkg::LAST_CHAR) begin
            need = (sb.font_h < GLYPH_ROWS) ? sb.font_h : GLYPH_ROWS;
            base = (int'(q.char_code) - int'(mpfb_pkg::FIRST_CHAR)) * GLYPH_ROWS;
            for (int r = 0; r < need; r++) begin
                if (!glyph_loaded[base + r]) begin
                    ld = make_req(mpfb_pkg::FUNC_LOAD_GLYPH, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  q.char_code, 4'(r), 10'($urandom_range(0, 1023)));
                    send_req(ld);
                end
            end
        end
        send_req(q);
    endtask

    task automatic write_cfg(logic idx, logic [4:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.due_results.size() != 0) @(negedge aclk);
    endtask

    task automatic directed_part();
        fb_req_t q;
        issue(make_req(mpfb_pkg::FUNC_READ_BYTE, 0, 0, 0, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_READ_BYTE, 0, 0, 0, 0, 0, 1023));
        issue(make_req(mpfb_pkg::FUNC_PIXEL, 0, 0, 1, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_PIXEL, 127, 63, 1, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_PIXEL, 128, 0, 1, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_PIXEL, 0, 64, 1, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_PIXEL, 255, 255, 1, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_READ_BYTE, 0, 0, 0, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_READ_BYTE, 0, 0, 0, 0, 0, 1023));
        issue(make_req(mpfb_pkg::FUNC_PIXEL, 0, 0, 0, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_LOAD_GLYPH, 0, 0, 0, 31, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_LOAD_GLYPH, 0, 0, 0, 127, 3, 0));
        q = make_req(mpfb_pkg::FUNC_LOAD_GLYPH, 0, 0, 0, mpfb_pkg::LAST_CHAR, 15, 0);
        q.row_bits = 16'hFFFF;
        issue(q);
        issue(make_req(FUNC_SPARE_6, 255, 255, 1, 255, 15, 1023));
        issue(make_req(FUNC_SPARE_7, 0, 0, 0, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_CHAR, 0, 0, 1, 31, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_CHAR, 0, 0, 1, 255, 0, 0));
        // Character at the bottom right corner of the screen, clipped at the right edge.
        issue(make_req(mpfb_pkg::FUNC_SET_CURSOR, 124, 62, 0, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_CHAR, 0, 0, 1, 65, 0, 0));
        // Character whose columns and rows wrap around past 255.
        issue(make_req(mpfb_pkg::FUNC_SET_CURSOR, 252, 255, 0, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_CHAR, 0, 0, 0, mpfb_pkg::LAST_CHAR, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_READ_BYTE, 0, 0, 0, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_READ_BYTE, 0, 0, 0, 0, 0, 1020));
        issue(make_req(mpfb_pkg::FUNC_FILL, 0, 0, 1, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_READ_BYTE, 0, 0, 0, 0, 0, 511));
        issue(make_req(mpfb_pkg::FUNC_FILL, 0, 0, 0, 0, 0, 0));
        issue(make_req(mpfb_pkg::FUNC_READ_BYTE, 0, 0, 0, 0, 0, 1023));
    endtask

    initial begin
        sb                = new();
        idle_pct          = 0;
        stall_pct         = 0;
        sent_count        = 0;
        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = mpfb_pkg::CFG_FONT_WIDTH;
        cfg_wdata         = 5'd0;
        s_valid           = 1'b0;
        m_ready           = 1'b0;
        s_func            = mpfb_pkg::FUNC_FILL;
        s_x_coord         = 8'd0;
        s_y_coord         = 8'd0;
        s_color           = 1'b0;
        s_char_code       = 8'd0;
        s_glyph_row_index = 4'd0;
        s_glyph_row_bits  = 16'd0;
        s_byte_address    = 10'd0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Short glyphs keep the directed part small; width stays at its reset value.
        write_cfg(mpfb_pkg::CFG_FONT_HEIGHT, 5'd2);
        directed_part();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            idle_pct  = idle_by_mode[p % 4];
            stall_pct = stall_by_mode[p % 4];
            write_cfg(mpfb_pkg::CFG_FONT_WIDTH, 5'(phase_w[p]));
            write_cfg(mpfb_pkg::CFG_FONT_HEIGHT, 5'(phase_h[p]));
            // Glyph loads pulled in by characters count toward the phase's share.
            while (sent_count < (p + 1) * PHASE_ITEMS) issue(random_req());
            drain();
        end

        stall_pct = 0;
        repeat (50) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("PASS mono_page_framebuffer_text_render");
        end else begin
            $display("FAIL mono_page_framebuffer_text_render");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("timeout with %0d results outstanding", sb.due_results.size());
        $display("FAIL mono_page_framebuffer_text_render");
        $finish;
    end

endmodule

// ===== files.f =====
design/mpfb_pkg.sv
design/mpfb_ctrl.sv
design/mpfb_dp.sv
design/mono_page_framebuffer_text_render.sv
sim/tb_mono_page_framebuffer_text_render.sv
